@@ rtl/core/rfop_pkg.sv @@
package rfop_pkg;

  // Build-time defaults for the top-level parameters
  localparam int MAX_FIELDS_DEF = 32;
  localparam int PAGE_BYTES_DEF = 4096;

  // Fixed payload and port widths
  localparam int BYTE_W      = 8;
  localparam int FIELD_IDX_W = 5;
  localparam int OFFSET_W    = 13;
  localparam int COUNT_W     = 6;
  localparam int TYPES_W     = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_TYPES = 1'b1;

  // Field type codes
  localparam logic [1:0] TYPE_INT     = 2'd0;
  localparam logic [1:0] TYPE_REAL    = 2'd1;
  localparam logic [1:0] TYPE_VARCHAR = 2'd2;

  typedef enum logic [2:0] {
    ST_BITMAP,
    ST_ADVANCE,
    ST_LENGTH,
    ST_VALUE,
    ST_EMIT,
    ST_ERROR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic bm_load;
    logic rec_start;
    logic rec_clear;
    logic fld_setup;
    logic fld_next;
    logic len_load;
    logic len_commit;
    logic val_load;
    logic val_commit;
    logic emit;
    logic emit_null;
    logic emit_err;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bm_done;
    logic fld_over;
    logic fld_last;
    logic cur_null;
    logic cur_varchar;
    logic rem_one;
    logic len_bad;
    logic len_zero;
    logic slot_free;
  } sts_t;

endpackage

@@ rtl/core/rfop_if.sv @@
interface rfop_in_if;
  logic                         valid;
  logic                         ready;
  logic [rfop_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rfop_out_if;
  logic                              valid;
  logic                              ready;
  logic [rfop_pkg::FIELD_IDX_W-1:0]  field_index;
  logic                              field_is_null;
  logic [rfop_pkg::OFFSET_W-1:0]     field_end_offset;
  logic [rfop_pkg::OFFSET_W-1:0]     store_length;
  logic                              last;
  logic                              error;

  modport source (
    output valid, output field_index, output field_is_null,
    output field_end_offset, output store_length, output last, output error,
    input ready
  );
  modport sink (
    input valid, input field_index, input field_is_null,
    input field_end_offset, input store_length, input last, input error,
    output ready
  );
endinterface

@@ rtl/core/rfop_ctrl.sv @@
module rfop_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rfop_pkg::sts_t   sts,
  output rfop_pkg::cmd_t   cmd
);
  import rfop_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BITMAP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_BITMAP: begin
        if (in_valid && sts.bm_done) state_next = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        if (sts.fld_over) begin
          state_next = ST_BITMAP;
        end else if (sts.cur_null) begin
          if (sts.slot_free && sts.fld_last) state_next = ST_BITMAP;
        end else if (sts.cur_varchar) begin
          state_next = ST_LENGTH;
        end else begin
          state_next = ST_VALUE;
        end
      end
      ST_LENGTH: begin
        if (in_valid && sts.rem_one) begin
          if (sts.len_bad) state_next = ST_ERROR;
          else if (sts.len_zero) state_next = ST_EMIT;
          else state_next = ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (in_valid && sts.rem_one) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) state_next = sts.fld_last ? ST_BITMAP : ST_ADVANCE;
      end
      ST_ERROR: begin
        if (sts.slot_free) state_next = ST_BITMAP;
      end
      default: state_next = ST_BITMAP;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_BITMAP: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.bm_load   = 1'b1;
          cmd.rec_start = sts.bm_done;
        end
      end
      ST_ADVANCE: begin
        if (sts.fld_over) begin
          cmd.rec_clear = 1'b1;
        end else if (sts.cur_null) begin
          if (sts.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_null = 1'b1;
            cmd.fld_next  = 1'b1;
            cmd.rec_clear = sts.fld_last;
          end
        end else begin
          cmd.fld_setup = 1'b1;
        end
      end
      ST_LENGTH: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.len_load   = 1'b1;
          cmd.len_commit = sts.rem_one && !sts.len_bad;
        end
      end
      ST_VALUE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.val_load   = 1'b1;
          cmd.val_commit = sts.rem_one;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.fld_next  = 1'b1;
          cmd.rec_clear = sts.fld_last;
        end
      end
      ST_ERROR: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_err  = 1'b1;
          cmd.rec_clear = 1'b1;
        end
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/rfop_dp.sv @@
module rfop_dp #(
  parameter int MAX_FIELDS = rfop_pkg::MAX_FIELDS_DEF,
  parameter int PAGE_BYTES = rfop_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rfop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfop_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [rfop_pkg::BYTE_W-1:0]       data_byte,
  input  rfop_pkg::cmd_t                    cmd,
  output rfop_pkg::sts_t                    sts,
  rfop_out_if.source                        result
);
  import rfop_pkg::*;

  localparam int OFF_W   = $clog2(PAGE_BYTES + 1);
  localparam int FIELD_W = $clog2(MAX_FIELDS + 1);
  localparam int MAXB    = (MAX_FIELDS + 7) / 8;
  localparam int NBITS   = 8 * MAXB;
  localparam int NIDX_W  = $clog2(NBITS);
  localparam int BC_W    = $clog2(MAXB + 1);
  localparam int IDXF_W  = BC_W + 3;
  localparam int SL_W    = OFF_W + 1;

  // Configuration
  logic [COUNT_W-1:0] field_count;
  logic [TYPES_W-1:0] field_types;

  // Record state
  logic [NBITS-1:0]   null_bits;
  logic [BC_W-1:0]    bm_cnt;
  logic [FIELD_W-1:0] field;
  logic [23:0]        len_acc;
  logic [OFF_W-1:0]   rem;
  logic [OFF_W-1:0]   len;
  logic [OFF_W-1:0]   offset;
  logic               out_valid;

  logic [FIELD_W-1:0]  n_eff;
  logic [BC_W-1:0]     need;
  logic [FIELD_W+2:0]  n_round;
  logic [IDXF_W-1:0]   nidx_full;
  logic [NIDX_W-1:0]   nidx;
  logic [31:0]         full_len;
  logic [1:0]          len_pos;
  logic [OFF_W-1:0]    add_amt;
  logic [OFF_W:0]      add_sum;
  logic [OFF_W-1:0]    offset_sat;
  logic [SL_W-1:0]     store_len;
  logic                varchar;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count <= COUNT_W'(1);
      field_types <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIELD_COUNT: field_count <= cfg_data[COUNT_W-1:0];
        CFG_FIELD_TYPES: field_types <= cfg_data[TYPES_W-1:0];
      endcase
    end
  end

  // Clamp the field count to 1..MAX_FIELDS
  always_comb begin
    if (field_count == '0) begin
      n_eff = FIELD_W'(1);
    end else if (field_count > COUNT_W'(MAX_FIELDS)) begin
      n_eff = FIELD_W'(MAX_FIELDS);
    end else begin
      n_eff = FIELD_W'(field_count);
    end
  end

  assign n_round = (FIELD_W + 3)'(n_eff) + (FIELD_W + 3)'(7);
  assign need    = BC_W'(n_round >> 3);

  // Bitmap is right-aligned in null_bits; field f sits at bit 8*need-1-f
  assign nidx_full = {need, 3'b000} - IDXF_W'(1) - IDXF_W'(field);
  assign nidx      = nidx_full[NIDX_W-1:0];

  assign varchar  = field_types[{5'(field), 1'b0} +: 2] == TYPE_VARCHAR;
  assign full_len = {data_byte, len_acc};
  assign len_pos  = 2'(3'd4 - 3'(rem));

  // Shared saturating offset adder
  assign add_amt    = (cmd.val_commit && varchar) ? len : OFF_W'(4);
  assign add_sum    = {1'b0, offset} + {1'b0, add_amt};
  assign offset_sat = (add_sum > (OFF_W + 1)'(PAGE_BYTES)) ? OFF_W'(PAGE_BYTES)
                                                           : add_sum[OFF_W-1:0];

  assign store_len = SL_W'(4) + SL_W'(need) + (SL_W'(n_eff) << 2) + SL_W'(offset);

  always_comb begin
    sts           = '0;
    sts.bm_done   = ((BC_W + 1)'(bm_cnt) + (BC_W + 1)'(1)) >= (BC_W + 1)'(need);
    sts.fld_over  = field >= n_eff;
    sts.fld_last  = ((FIELD_W + 1)'(field) + (FIELD_W + 1)'(1)) >= (FIELD_W + 1)'(n_eff);
    sts.cur_null  = null_bits[nidx];
    sts.cur_varchar = varchar;
    sts.rem_one   = rem == OFF_W'(1);
    sts.len_bad   = data_byte[7] || (full_len > 32'(PAGE_BYTES));
    sts.len_zero  = full_len == '0;
    sts.slot_free = !out_valid || result.ready;
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bm_cnt <= '0;
      field  <= '0;
      offset <= '0;
      rem    <= '0;
    end else if (cmd.rec_clear) begin
      bm_cnt <= '0;
      field  <= '0;
      offset <= '0;
      rem    <= '0;
    end else begin
      if (cmd.rec_start) begin
        bm_cnt <= '0;
        field  <= '0;
        offset <= '0;
      end else if (cmd.bm_load) begin
        bm_cnt <= bm_cnt + BC_W'(1);
      end
      if (cmd.fld_next) field <= field + FIELD_W'(1);
      if (cmd.len_commit || cmd.val_commit) offset <= offset_sat;
      if (cmd.fld_setup) begin
        rem <= OFF_W'(4);
      end else if (cmd.len_commit) begin
        rem <= OFF_W'(full_len);
      end else if (cmd.len_load || cmd.val_load) begin
        rem <= rem - OFF_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.bm_load) null_bits <= (null_bits << 8) | NBITS'(data_byte);
    if (cmd.fld_setup) begin
      len_acc <= '0;
    end else if (cmd.len_load && len_pos != 2'd3) begin
      len_acc[{len_pos, 3'b000} +: 8] <= data_byte;
    end
    if (cmd.len_commit) len <= OFF_W'(full_len);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.field_index      <= FIELD_IDX_W'(field);
      result.field_is_null    <= cmd.emit_null;
      result.field_end_offset <= OFFSET_W'(offset);
      result.last             <= cmd.emit_err || sts.fld_last;
      result.error            <= cmd.emit_err;
      result.store_length     <= (!cmd.emit_err && sts.fld_last) ? OFFSET_W'(store_len)
                                                                 : '0;
    end
  end

  assign result.valid = out_valid;

endmodule

@@ rtl/core/record_field_offset_parser_unit.sv @@
// Record field offset parser.
// The record channel takes one byte of an API-format record per beat: the
// null bitmap (ceil(n/8) bytes, MSB first), then the values of the non-null
// fields. The result channel gives one beat per field with its cumulative
// end offset; the final beat of a record has last set and carries the
// store-format length. A bad varchar length gives one error beat and ends
// the record. Configure field_count and field_types through cfg_we,
// cfg_index and cfg_data while no record is in flight.
// Bitmap and value bytes are taken as they arrive. Each field also takes a
// controller step (setup of a non-null field, or the emit of a null one),
// and each non-null field an emit step after its last byte. A result
// reaches the output register in the cycle after its emit step.
// Reset clears the record state, field_count to 1 and field_types to 0.
// A stalled receiver holds the output register; value bytes keep flowing
// until the next emit, then the record channel waits.
module record_field_offset_parser_unit #(
  parameter int MAX_FIELDS = rfop_pkg::MAX_FIELDS_DEF,
  parameter int PAGE_BYTES = rfop_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rfop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfop_pkg::CFG_DATA_W-1:0]   cfg_data,
  rfop_in_if.sink                           record,
  rfop_out_if.source                        result
);
  import rfop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the record: bitmap, per-field setup, length and value bytes, emits
  rfop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (record.valid),
    .in_ready (record.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold configuration, counters, offset adder and the output register
  rfop_dp #(
    .MAX_FIELDS (MAX_FIELDS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (record.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule
